// ===== rtl/core/ppe_pkg.sv =====
// ppe_pkg: types, constants and helpers of the particle pool engine
// no dependencies
package ppe_pkg;
	localparam int DOTS = 32;
	localparam int IDX_W = $clog2(DOTS);
	localparam logic [6:0] DOTS_C = 7'(DOTS);

	typedef enum logic [1:0] {
		MODE_SPAWN = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_ACTIVE  = 2'd0,
		REG_GRAVITY = 2'd1,
		REG_JITTER  = 2'd2
	} reg_idx_t;

	localparam logic [5:0] AGE_LIMIT = 6'd30;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] vel_z;
		logic [15:0] jitter_x;
		logic [15:0] jitter_y;
		logic [15:0] jitter_z;
		logic [5:0]  life_offset;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  dot_index;
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
		logic [6:0]  out_life;
		logic        empty_res;
		logic        last;
	} out_item_t;

	// one pool entry as held in the memory
	typedef struct packed {
		logic [5:0]  age;
		logic [6:0]  life;
		logic [15:0] damping;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
	} dot_t;

	function automatic logic [31:0] sat32(input logic signed [33:0] x);
		if (x > 34'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
		if (x < -34'sh0_8000_0000) return 32'h8000_0000;
		return x[31:0];
	endfunction

	// round((1024+life)*65536/1280), ties up
	// equals floor(((1024+life)*256+2)/5); the divide by 5 is a reciprocal
	// multiply, exact for every 7-bit life
	function automatic logic [15:0] damping_of(input logic [6:0] life);
		logic [18:0] m;
		logic [39:0] p;
		m = (19'(life) + 19'd1024) * 19'd256 + 19'd2;
		p = 40'(m) * 40'd419431;
		return 16'(p >> 21);
	endfunction
endpackage

// ===== rtl/core/ppe_stream_if.sv =====
// ppe_stream_if: valid/ready channel with a typed payload
// depends on nothing but the payload type given as a parameter
interface ppe_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ppe_cfg_if.sv =====
// ppe_cfg_if: register write channel
// no dependencies
interface ppe_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/ppe_update.sv =====
// ppe_update: two-stage euler update of one particle, multiplies registered
// depends on ppe_pkg
module ppe_update (
	input  logic            clk,
	input  ppe_pkg::dot_t   dot_in,
	input  logic [31:0]     gravity,
	output ppe_pkg::dot_t   dot_out
);
	ppe_pkg::dot_t      d_s1;
	logic signed [48:0] px_s1, py_s1, pz_s1;
	logic [31:0]        vy_g;
	logic [31:0]        nvx, nvy, nvz;

	assign vy_g = ppe_pkg::sat32(34'(signed'(dot_in.vy)) + 34'(signed'(gravity)));

	always_ff @(posedge clk) begin
		d_s1 <= dot_in;
		px_s1 <= 49'(signed'(dot_in.vx)) * signed'({1'b0, dot_in.damping});
		py_s1 <= 49'(signed'(vy_g)) * signed'({1'b0, dot_in.damping});
		pz_s1 <= 49'(signed'(dot_in.vz)) * signed'({1'b0, dot_in.damping});
	end

	// magnitude never grows, so the rounded product fits 32 bits
	assign nvx = 32'((px_s1 + 49'sd32768) >>> 16);
	assign nvy = 32'((py_s1 + 49'sd32768) >>> 16);
	assign nvz = 32'((pz_s1 + 49'sd32768) >>> 16);

	always_comb begin
		dot_out = d_s1;
		dot_out.age = d_s1.age + 6'd1;
		dot_out.vx = nvx;
		dot_out.vy = nvy;
		dot_out.vz = nvz;
		dot_out.px = ppe_pkg::sat32(34'(signed'(d_s1.px)) + 34'(signed'(nvx)));
		dot_out.py = ppe_pkg::sat32(34'(signed'(d_s1.py)) + 34'(signed'(nvy)));
		dot_out.pz = ppe_pkg::sat32(34'(signed'(d_s1.pz)) + 34'(signed'(nvz)));
	end
endmodule

// ===== rtl/core/particle_pool_engine.sv =====
// particle_pool_engine: top level, pool memory, sequencer and register file
// depends on ppe_pkg, ppe_stream_if, ppe_cfg_if, ppe_update
//
// Channels: item_in takes spawn, tick and read items; item_out gives the
// particles of a read; cfg writes active_dots (0), gravity_step (1) and
// jitter_range (2). Every transfer is a valid/ready handshake.
// A spawn registers the jitter products, then does one memory write. A tick
// walks the active entries through the pool memory: scan, read and two
// update stages with the write back in the last for a live entry; scan,
// read and write back for an entry that is freed; scan only for an idle one.
// A read walks the same way (scan, read, emit per live entry, scan only
// per idle entry) and stalls while the output register is full and not taken.
// Items are handled one at a time; item_in is ready only between items.
// Reset clears the used flags, the spawn cursor and the registers to their
// defaults; entries are not cleared and need no clearing pass.
// A read with no live particle gives one result with empty_res and last set.
module particle_pool_engine (
	input  logic clk,
	input  logic arst_n,
	ppe_stream_if.sink   item_in,
	ppe_stream_if.source item_out,
	ppe_cfg_if.sink      cfg
);
	typedef enum logic [3:0] {
		S_IDLE, S_SPAWN1, S_SPAWN2, S_SCAN, S_RD, S_UPD1, S_UPD2, S_EMIT, S_EMPTY
	} state_t;

	state_t              state_q;
	ppe_pkg::in_item_t   in_q;
	logic [6:0]          active_q;
	logic [31:0]         gravity_q;
	logic [30:0]         jitter_q;
	logic [ppe_pkg::DOTS-1:0] used_q;
	logic [ppe_pkg::IDX_W-1:0] cursor_q;
	logic [ppe_pkg::IDX_W:0]   idx_q;
	logic                found_q;
	logic signed [47:0]  jx_s1, jy_s1, jz_s1;
	logic [6:0]          n_eff;

	ppe_pkg::dot_t mem [ppe_pkg::DOTS];
	ppe_pkg::dot_t rd_q;
	ppe_pkg::dot_t wr_d;
	logic          wr_en;
	logic [ppe_pkg::IDX_W-1:0] wr_a, rd_a;
	ppe_pkg::dot_t upd;
	ppe_pkg::out_item_t out_q;
	logic          out_v_q;
	logic          out_load;
	logic [ppe_pkg::IDX_W-1:0] cur;
	logic [ppe_pkg::IDX_W:0]   nxt;
	logic          more;

	assign n_eff = (active_q == 7'd0) ? 7'd1 :
		(active_q > ppe_pkg::DOTS_C) ? ppe_pkg::DOTS_C : active_q;
	assign cur = idx_q[ppe_pkg::IDX_W-1:0];
	assign nxt = idx_q + 1'b1;
	assign more = 7'(nxt) < n_eff;

	// output register takes a new result this cycle
	assign out_load = (state_q == S_EMIT || state_q == S_EMPTY) &&
		(!out_v_q || item_out.ready);

	assign cfg.ready = (state_q == S_IDLE);
	assign item_in.ready = (state_q == S_IDLE);
	assign item_out.valid = out_v_q;
	assign item_out.data = out_q;
	assign rd_a = cur;

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_a];
		if (wr_en) mem[wr_a] <= wr_d;
	end

	ppe_update u_upd (.clk(clk), .dot_in(rd_q), .gravity(gravity_q), .dot_out(upd));

	always_ff @(posedge clk) begin
		jx_s1 <= 48'(signed'({1'b0, jitter_q})) * signed'(in_q.jitter_x);
		jy_s1 <= 48'(signed'({1'b0, jitter_q})) * signed'(in_q.jitter_y);
		jz_s1 <= 48'(signed'({1'b0, jitter_q})) * signed'(in_q.jitter_z);
	end

	always_comb begin
		logic [6:0] life;
		logic signed [47:0] ox, oy, oz;
		life = 7'd32 + 7'(in_q.life_offset);
		ox = (jx_s1 + 48'sd16384) >>> 15;
		oy = (jy_s1 + 48'sd16384) >>> 15;
		oz = (jz_s1 + 48'sd16384) >>> 15;
		wr_en = 1'b0;
		wr_a = cur;
		wr_d = upd;
		if (state_q == S_SPAWN2) begin
			wr_en = 1'b1;
			wr_a = (7'(cursor_q) < n_eff) ? cursor_q : '0;
			wr_d.age = '0;
			wr_d.life = life;
			wr_d.damping = ppe_pkg::damping_of(life);
			wr_d.px = ppe_pkg::sat32(34'(signed'(in_q.pos_x)) + 34'(ox));
			wr_d.py = ppe_pkg::sat32(34'(signed'(in_q.pos_y)) + 34'(oy));
			wr_d.pz = ppe_pkg::sat32(34'(signed'(in_q.pos_z)) + 34'(oz));
			wr_d.vx = in_q.vel_x;
			wr_d.vy = in_q.vel_y;
			wr_d.vz = in_q.vel_z;
		end else if (state_q == S_UPD2) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			active_q <= 7'd32;
			gravity_q <= 32'd2048;
			jitter_q <= '0;
			used_q <= '0;
			cursor_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			out_v_q <= 1'b0;
			in_q <= '0;
			out_q <= '0;
		end else begin
			if (item_out.valid && item_out.ready && !out_load) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg.valid) begin
						unique case (cfg.index)
							ppe_pkg::REG_ACTIVE:  active_q <= cfg.wdata[6:0];
							ppe_pkg::REG_GRAVITY: gravity_q <= cfg.wdata;
							ppe_pkg::REG_JITTER:  jitter_q <= cfg.wdata[30:0];
							default: ;
						endcase
					end
					if (item_in.valid) begin
						in_q <= item_in.data;
						idx_q <= '0;
						found_q <= 1'b0;
						unique case (item_in.data.mode)
							ppe_pkg::MODE_SPAWN: state_q <= S_SPAWN1;
							ppe_pkg::MODE_TICK, ppe_pkg::MODE_READ: state_q <= S_SCAN;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SPAWN1: state_q <= S_SPAWN2;
				S_SPAWN2: begin
					used_q[wr_a] <= 1'b1;
					cursor_q <= (7'(wr_a) + 7'd1 >= n_eff) ? '0 :
						ppe_pkg::IDX_W'(7'(wr_a) + 7'd1);
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					// memory address is cur; data shows next cycle
					if (used_q[cur]) begin
						state_q <= S_RD;
					end else if (more) begin
						idx_q <= nxt;
					end else if (in_q.mode == ppe_pkg::MODE_READ && !found_q) begin
						state_q <= S_EMPTY;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					if (in_q.mode == ppe_pkg::MODE_TICK) begin
						if (rd_q.age < ppe_pkg::AGE_LIMIT) begin
							state_q <= S_UPD1;
						end else begin
							used_q[cur] <= 1'b0;
							state_q <= S_UPD2;
						end
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_UPD1: state_q <= S_UPD2;
				S_UPD2: begin
					// freed entries also write back the whole updated entry; data is never read again
					if (more) begin
						idx_q <= nxt;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						logic lst;
						lst = 1'b1;
						for (int k = 0; k < ppe_pkg::DOTS; k++)
							if (k > int'(cur) && k < int'(n_eff) && used_q[k]) lst = 1'b0;
						out_v_q <= 1'b1;
						out_q.dot_index <= 6'(cur);
						out_q.out_x <= rd_q.px;
						out_q.out_y <= rd_q.py;
						out_q.out_z <= rd_q.pz;
						out_q.out_life <= rd_q.life;
						out_q.empty_res <= 1'b0;
						out_q.last <= lst;
						found_q <= 1'b1;
						if (more && !lst) begin
							idx_q <= nxt;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMPTY: begin
					if (out_load) begin
						out_v_q <= 1'b1;
						out_q.dot_index <= '0;
						out_q.out_x <= '0;
						out_q.out_y <= '0;
						out_q.out_z <= '0;
						out_q.out_life <= '0;
						out_q.empty_res <= 1'b1;
						out_q.last <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
